[sv/stffa_pkg.sv]
// Package for the sorted-table first-fit allocator.
// Holds the request and result structs, status and mode codes.
// No dependencies.
`default_nettype none
package stffa_pkg;

    localparam int LEN_W = 13;
    localparam int OFF_W = 12;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOSPACE  = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [LEN_W-1:0] requested_length;
        logic [OFF_W-1:0] location;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] granted_offset;
        logic [LEN_W-1:0] found_length;
        logic [4:0]       peak_entries;
        logic [LEN_W-1:0] peak_words_used;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic evaluate;
        logic commit;
        logic sum_step;
        logic finish;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_done;
        logic is_alloc;
    } dp_status_t;

endpackage
`default_nettype wire

[sv/stffa_datapath.sv]
// Datapath of the sorted-table first-fit allocator: entry table, gap search,
// shift, usage sum and peak registers. Depends on stffa_pkg.
`default_nettype none
module stffa_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int POOL_WORDS    = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire stffa_pkg::request_t  req_in,
    input  wire stffa_pkg::ctrl_t     ctrl,
    output stffa_pkg::dp_status_t     dp_status,
    output stffa_pkg::result_t        result_out
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = stffa_pkg::LEN_W;
    localparam int OW = stffa_pkg::OFF_W;
    localparam int SUM_W = LW + CNT_W;
    localparam logic [LW:0] POOL = (LW + 1)'(POOL_WORDS);

    logic [OW-1:0] base_reg [TABLE_ENTRIES];
    logic [LW-1:0] len_reg  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    stffa_pkg::request_t req_reg;
    logic [TABLE_ENTRIES-1:0] hit_reg;
    logic [TABLE_ENTRIES-1:0] fit_reg;
    logic [LW:0] gap_end_reg [TABLE_ENTRIES];
    logic [1:0] status_reg;
    logic [OW-1:0] granted_reg;
    logic [LW-1:0] found_reg;
    logic [IDX_W-1:0] sum_idx_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [4:0] peak_cnt_reg;
    logic [LW-1:0] peak_use_reg;
    logic sum_done_reg;

    logic [TABLE_ENTRIES-1:0] hit_c, fit_c;
    logic [LW:0] end_c [TABLE_ENTRIES];

    // Gap test for every slot in parallel; prev end for slot 0 is zero.
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            logic [LW:0] pe;
            logic [LW:0] nb;
            logic [LW:0] rl;
            pe = (i == 0) ? '0 : ({1'b0, LW'(base_reg[(i == 0) ? 0 : i - 1])}
                 + {1'b0, len_reg[(i == 0) ? 0 : i - 1]});
            nb = valid_reg[i] ? (LW + 1)'(base_reg[i]) : POOL;
            rl = {1'b0, req_reg.requested_length};
            end_c[i] = pe;
            fit_c[i] = (i == 0 || valid_reg[(i == 0) ? 0 : i - 1])
                       && (nb >= pe) && (nb - pe >= rl);
            hit_c[i] = valid_reg[i] && (base_reg[i] == req_reg.location);
        end
    end

    logic                     any_fit, any_hit;
    logic [IDX_W-1:0]         fit_idx, hit_idx;
    always_comb
    begin
        fit_idx = '0;
        hit_idx = '0;
        any_fit = 1'b0;
        any_hit = 1'b0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (fit_reg[i]) begin
                fit_idx = IDX_W'(i);
                any_fit = 1'b1;
            end
            if (hit_reg[i]) begin
                hit_idx = IDX_W'(i);
                any_hit = 1'b1;
            end
        end
    end

    logic alloc_ok;
    assign alloc_ok = !valid_reg[TABLE_ENTRIES-1]
                      && req_reg.requested_length != '0
                      && {1'b0, req_reg.requested_length} <= POOL && any_fit;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            req_reg <= req_in;
        if (ctrl.evaluate) begin
            hit_reg <= hit_c;
            fit_reg <= fit_c;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                gap_end_reg[i] <= end_c[i];
        end
        if (ctrl.commit) begin
            unique case (stffa_pkg::mode_t'(req_reg.mode))
                stffa_pkg::MODE_ALLOC:
                begin
                    found_reg <= '0;
                    if (valid_reg[TABLE_ENTRIES-1]) begin
                        status_reg <= stffa_pkg::ST_FULL;
                        granted_reg <= '0;
                    end
                    else if (!alloc_ok) begin
                        status_reg <= stffa_pkg::ST_NOSPACE;
                        granted_reg <= '0;
                    end
                    else begin
                        status_reg <= stffa_pkg::ST_OK;
                        granted_reg <= OW'(gap_end_reg[fit_idx]);
                        for (int j = 0; j < TABLE_ENTRIES; j++) begin
                            if (j > fit_idx && j > 0) begin
                                base_reg[j] <= base_reg[(j == 0) ? 0 : j - 1];
                                len_reg[j]  <= len_reg[(j == 0) ? 0 : j - 1];
                            end
                        end
                        base_reg[fit_idx] <= OW'(gap_end_reg[fit_idx]);
                        len_reg[fit_idx]  <= req_reg.requested_length;
                    end
                end
                stffa_pkg::MODE_FREE:
                begin
                    granted_reg <= '0;
                    found_reg <= '0;
                    status_reg <= any_hit ? stffa_pkg::ST_OK : stffa_pkg::ST_NOTFOUND;
                    if (any_hit)
                        for (int j = 0; j < TABLE_ENTRIES - 1; j++)
                            if (j >= hit_idx) begin
                                base_reg[j] <= base_reg[j+1];
                                len_reg[j]  <= len_reg[j+1];
                            end
                end
                stffa_pkg::MODE_QUERY:
                begin
                    granted_reg <= '0;
                    status_reg <= any_hit ? stffa_pkg::ST_OK : stffa_pkg::ST_NOTFOUND;
                    found_reg <= any_hit ? len_reg[hit_idx] : '0;
                end
                default:
                begin
                    granted_reg <= '0;
                    found_reg <= '0;
                    status_reg <= stffa_pkg::ST_NOTFOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            peak_cnt_reg <= '0;
            peak_use_reg <= '0;
            sum_idx_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            sum_done_reg <= 1'b0;
        end else begin
            if (ctrl.commit) begin
                sum_idx_reg <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
                sum_done_reg <= 1'b0;
                if (req_reg.mode == stffa_pkg::MODE_ALLOC && alloc_ok)
                    valid_reg <= {valid_reg[TABLE_ENTRIES-2:0], 1'b1};
                else if (req_reg.mode == stffa_pkg::MODE_FREE && any_hit)
                    valid_reg <= {1'b0, valid_reg[TABLE_ENTRIES-1:1]};
            end
            if (ctrl.sum_step && !sum_done_reg) begin
                if (valid_reg[sum_idx_reg]) begin
                    sum_reg <= sum_reg + SUM_W'(len_reg[sum_idx_reg]);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (sum_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                    sum_done_reg <= 1'b1;
                else
                    sum_idx_reg <= sum_idx_reg + 1'b1;
            end
            if (ctrl.finish && req_reg.mode == stffa_pkg::MODE_ALLOC) begin
                if (5'(cnt_reg) > peak_cnt_reg)
                    peak_cnt_reg <= 5'(cnt_reg);
                if (sum_reg > SUM_W'(peak_use_reg))
                    peak_use_reg <= LW'(sum_reg);
            end
        end
    end

    assign dp_status.sum_done = sum_done_reg;
    assign dp_status.is_alloc = (req_reg.mode == stffa_pkg::MODE_ALLOC);

    assign result_out.status = status_reg;
    assign result_out.granted_offset = granted_reg;
    assign result_out.found_length = found_reg;
    assign result_out.peak_entries = peak_cnt_reg;
    assign result_out.peak_words_used = peak_use_reg;

endmodule
`default_nettype wire

[sv/stffa_ctrl.sv]
// Controller of the sorted-table first-fit allocator.
// Sequences load, evaluate, commit, usage sum (allocate only), finish and reply. Depends on stffa_pkg.
`default_nettype none
module stffa_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire stffa_pkg::dp_status_t  dp_status,
    output stffa_pkg::ctrl_t            ctrl,
    output logic                        busy,
    output logic                        done
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_COMMIT = 6'b000100,
        S_SUM    = 6'b001000,
        S_FINISH = 6'b010000,
        S_REPLY  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.load = start;
                if (start)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                ctrl.evaluate = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctrl.commit = 1'b1;
                state_next = dp_status.is_alloc ? S_SUM : S_REPLY;
            end
            S_SUM:
            begin
                ctrl.sum_step = 1'b1;
                if (dp_status.sum_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                ctrl.finish = 1'b1;
                state_next = S_REPLY;
            end
            S_REPLY: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_REPLY);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("reply not followed by idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule
`default_nettype wire

[sv/sorted_table_first_fit_allocator.sv]
// Top level of the sorted-table first-fit allocator.
// Instantiates stffa_ctrl and stffa_datapath; depends on stffa_pkg.
//
// Usage: drive request and raise start while busy is low; the request is
// accepted at that clock edge. Exactly one result follows, shown on result
// for one cycle while done is high; the receiver cannot stall and must take
// it then. busy stays high from acceptance through the done cycle.
// For free, query and unused modes the controller steps through evaluate,
// commit and reply. Allocate adds a usage sum after commit that walks the
// entry table one slot per cycle, then a finish step that updates the peak
// marks, before the reply. A new request is not taken while one is in
// progress: the controller returns to idle after the done cycle, and the
// next request is accepted from idle.
// Reset clears the valid bits, the peak marks and the controller; entry
// contents are not cleared and need no clearing pass.
`default_nettype none
module sorted_table_first_fit_allocator #(
    parameter int TABLE_ENTRIES = 16,
    parameter int POOL_WORDS    = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire stffa_pkg::request_t request,
    output logic                     busy,
    output logic                     done,
    output stffa_pkg::result_t       result
);

    stffa_pkg::ctrl_t      ctrl;
    stffa_pkg::dp_status_t dp_status;

    stffa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .dp_status(dp_status),
        .ctrl(ctrl), .busy(busy), .done(done)
    );

    stffa_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .POOL_WORDS(POOL_WORDS)) u_dp (
        .clk(clk), .rst_n(rst_n), .req_in(request), .ctrl(ctrl),
        .dp_status(dp_status), .result_out(result)
    );

endmodule
`default_nettype wire

[bench/stffa_checker.sv]
// Checker for the sorted-table first-fit allocator: watches accepted requests
// and result strobes, predicts each result from its own table copy and compares.
// Depends on stffa_pkg.
module stffa_checker #(
    parameter int TABLE_ENTRIES = 16,
    parameter int POOL_WORDS    = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  stffa_pkg::request_t request,
    input  logic                done,
    input  stffa_pkg::result_t  result,
    output int                  fail_count,
    output int                  pending,
    output int                  live_blocks,
    output int                  results_seen
);
    localparam int OFF_W = stffa_pkg::OFF_W;
    localparam int LEN_W = stffa_pkg::LEN_W;

    logic [OFF_W-1:0]   blk_base [TABLE_ENTRIES];
    logic [LEN_W-1:0]   blk_len [TABLE_ENTRIES];
    logic               blk_live [TABLE_ENTRIES];
    logic [4:0]         hw_count;
    logic [LEN_W-1:0]   hw_words;
    stffa_pkg::result_t expected_results[$];

    function automatic int find_block(logic [OFF_W-1:0] loc);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (blk_live[i] && blk_base[i] == loc)
                return i;
        return -1;
    endfunction

    task automatic insert_block(int k, logic [OFF_W-1:0] b, logic [LEN_W-1:0] l);
        for (int j = TABLE_ENTRIES - 1; j > k; j--)
        begin
            blk_base[j] = blk_base[j-1];
            blk_len[j]  = blk_len[j-1];
            blk_live[j] = blk_live[j-1];
        end
        blk_base[k] = b;
        blk_len[k]  = l;
        blk_live[k] = 1'b1;
    endtask

    task automatic allocate_block(input int req, output stffa_pkg::status_t st,
                                  output int granted);
        int prev_end;
        granted = 0;
        if (blk_live[TABLE_ENTRIES-1])
        begin
            st = stffa_pkg::ST_FULL;
            return;
        end
        if (req == 0 || req > POOL_WORDS)
        begin
            st = stffa_pkg::ST_NOSPACE;
            return;
        end
        if (!blk_live[0] || int'(blk_base[0]) >= req)
        begin
            insert_block(0, '0, LEN_W'(req));
            st = stffa_pkg::ST_OK;
            return;
        end
        for (int i = 1; i < TABLE_ENTRIES; i++)
        begin
            prev_end = int'(blk_base[i-1]) + int'(blk_len[i-1]);
            if (!blk_live[i])
            begin
                if (prev_end <= POOL_WORDS && POOL_WORDS - prev_end >= req)
                begin
                    insert_block(i, OFF_W'(prev_end), LEN_W'(req));
                    granted = prev_end;
                    st = stffa_pkg::ST_OK;
                end
                else
                    st = stffa_pkg::ST_NOSPACE;
                return;
            end
            if (int'(blk_base[i]) >= prev_end && int'(blk_base[i]) - prev_end >= req)
            begin
                insert_block(i, OFF_W'(prev_end), LEN_W'(req));
                granted = prev_end;
                st = stffa_pkg::ST_OK;
                return;
            end
        end
        st = stffa_pkg::ST_NOSPACE;
    endtask

    task automatic predict_result(stffa_pkg::request_t rq);
        stffa_pkg::result_t r;
        stffa_pkg::status_t st;
        int granted;
        int k;
        int cnt;
        int used;
        r = '0;
        st = stffa_pkg::ST_NOTFOUND;
        case (stffa_pkg::mode_t'(rq.mode))
            stffa_pkg::MODE_ALLOC:
            begin
                allocate_block(int'(rq.requested_length), st, granted);
                r.granted_offset = OFF_W'(granted);
                cnt = 0;
                used = 0;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (blk_live[i])
                    begin
                        cnt++;
                        used += int'(blk_len[i]);
                    end
                if (cnt > int'(hw_count))
                    hw_count = 5'(cnt);
                if (used > int'(hw_words))
                    hw_words = LEN_W'(used);
            end
            stffa_pkg::MODE_FREE:
            begin
                k = find_block(rq.location);
                if (k >= 0)
                begin
                    for (int j = k; j < TABLE_ENTRIES - 1; j++)
                    begin
                        blk_base[j] = blk_base[j+1];
                        blk_len[j]  = blk_len[j+1];
                        blk_live[j] = blk_live[j+1];
                    end
                    blk_live[TABLE_ENTRIES-1] = 1'b0;
                    st = stffa_pkg::ST_OK;
                end
            end
            stffa_pkg::MODE_QUERY:
            begin
                k = find_block(rq.location);
                if (k >= 0)
                begin
                    st = stffa_pkg::ST_OK;
                    r.found_length = blk_len[k];
                end
            end
            default: ;
        endcase
        r.status = st;
        r.peak_entries = hw_count;
        r.peak_words_used = hw_words;
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stffa_pkg::result_t e;
        int n;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                blk_live[i] = 1'b0;
                blk_base[i] = '0;
                blk_len[i]  = '0;
            end
            hw_count = '0;
            hw_words = '0;
            expected_results.delete();
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result %p", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (result !== e)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch: expected %p, got %p", e, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                predict_result(request);
        end
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (blk_live[i])
                n++;
        live_blocks = n;
        pending = expected_results.size();
    end
endmodule

[bench/tb_sorted_table_first_fit_allocator.sv]
// Testbench top for the sorted-table first-fit allocator: drives directed and
// random requests in phases with differing idle gaps and gives the verdict from stffa_checker.
// Depends on stffa_pkg, sorted_table_first_fit_allocator and stffa_checker.
module tb_sorted_table_first_fit_allocator;
    localparam int LIMIT = 400000;
    localparam int OFF_W = stffa_pkg::OFF_W;
    localparam int LEN_W = stffa_pkg::LEN_W;

    logic                clk;
    logic                rst_n;
    logic                start;
    stffa_pkg::request_t request;
    logic                busy;
    logic                done;
    stffa_pkg::result_t  result;
    int                  fail_count;
    int                  pending;
    int                  live_blocks;
    int                  results_seen;
    int                  cycles;
    int                  idle_pct;
    logic [OFF_W-1:0]    granted_bases[$];

    sorted_table_first_fit_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .done(done), .result(result)
    );

    stffa_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending),
        .live_blocks(live_blocks), .results_seen(results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (done && result.status == stffa_pkg::ST_OK && result.granted_offset != 0)
            granted_bases.push_back(result.granted_offset);
        if (cycles == LIMIT)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(stffa_pkg::mode_t m, int len, int loc);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        start <= 1'b1;
        request <= '{mode: m, requested_length: LEN_W'(len), location: OFF_W'(loc)};
        @(negedge clk);
        start <= 1'b0;
        request <= '{mode: stffa_pkg::mode_t'($urandom_range(3)),
                     requested_length: LEN_W'($urandom),
                     location: OFF_W'($urandom)};
        while (busy)
            @(negedge clk);
    endtask

    function automatic int pick_location();
        if (granted_bases.size() != 0 && $urandom_range(9) < 8)
            return int'(granted_bases[$urandom_range(granted_bases.size() - 1)]);
        if ($urandom_range(3) == 0)
            return 0;
        return $urandom_range(4095);
    endfunction

    initial
    begin
        int len;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(stffa_pkg::MODE_ALLOC, 0, 0);
        send_request(stffa_pkg::MODE_FREE, 0, 0);
        send_request(stffa_pkg::MODE_QUERY, 0, 4095);
        send_request(stffa_pkg::MODE_NONE, 8191, 4095);
        send_request(stffa_pkg::MODE_ALLOC, 8191, 4095);
        send_request(stffa_pkg::MODE_ALLOC, 4097, 0);
        send_request(stffa_pkg::MODE_ALLOC, 4096, 0);
        send_request(stffa_pkg::MODE_QUERY, 0, 0);
        send_request(stffa_pkg::MODE_ALLOC, 1, 0);
        send_request(stffa_pkg::MODE_FREE, 0, 0);
        send_request(stffa_pkg::MODE_FREE, 0, 0);
        for (int i = 0; i < 16; i++)
            send_request(stffa_pkg::MODE_ALLOC, (i == 15) ? 4096 - 15 * 200 : 200, 0);
        send_request(stffa_pkg::MODE_ALLOC, 1, 0);
        send_request(stffa_pkg::MODE_FREE, 0, 200);
        send_request(stffa_pkg::MODE_ALLOC, 201, 0);
        send_request(stffa_pkg::MODE_ALLOC, 200, 0);
        for (int i = 0; i < 16; i++)
            send_request(stffa_pkg::MODE_FREE, 0, i * 200);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 71 : (ph == 3) ? 8 : 0;
            for (int n = 0; n < 340; n++)
            begin
                case ($urandom_range(9)) inside
                    [0:3]:
                    begin
                        case ($urandom_range(7))
                            0: len = $urandom_range(8191);
                            1: len = 0;
                            2: len = $urandom_range(4096, 1024);
                            default: len = $urandom_range(400, 1);
                        endcase
                        if (live_blocks > 12 && $urandom_range(1))
                            send_request(stffa_pkg::MODE_FREE, 0, pick_location());
                        else
                            send_request(stffa_pkg::MODE_ALLOC, len, $urandom);
                    end
                    [4:6]: send_request(stffa_pkg::MODE_FREE, $urandom, pick_location());
                    [7:8]: send_request(stffa_pkg::MODE_QUERY, $urandom, pick_location());
                    default: send_request(stffa_pkg::MODE_NONE, $urandom, $urandom);
                endcase
            end
        end

        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("Ran %0d requests' results through allocate, free, query and unused modes,",
                 results_seen);
        $display("including full table, zero length, no space and miss cases.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
